// ===== design/dhlt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dhlt_pkg;

  typedef struct packed {
    logic signed [15:0] twist_angle;
    logic signed [23:0] link_length;
    logic signed [23:0] link_offset;
    logic signed [15:0] joint_angle;
  } dhlt_in_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [23:0] px;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [23:0] py;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [23:0] pz;
  } dhlt_out_t;

  localparam int TAB_LEN = 24;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [15:0] ROT_MAX     = 16'sd16384;
  localparam logic signed [15:0] ROT_MIN     = -16'sd16384;

  // atan(2^-i) in q3.30, truncated
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    unique case (i)
      0: v = 34'sd843314856;   1: v = 34'sd497837829;
      2: v = 34'sd263043836;   3: v = 34'sd133525158;
      4: v = 34'sd67021686;    5: v = 34'sd33543515;
      6: v = 34'sd16775850;    7: v = 34'sd8388437;
      8: v = 34'sd4194282;     9: v = 34'sd2097149;
      10: v = 34'sd1048575;    11: v = 34'sd524287;
      12: v = 34'sd262143;     13: v = 34'sd131071;
      14: v = 34'sd65535;      15: v = 34'sd32767;
      16: v = 34'sd16383;      17: v = 34'sd8191;
      18: v = 34'sd4095;       19: v = 34'sd2047;
      20: v = 34'sd1023;       21: v = 34'sd511;
      22: v = 34'sd255;        23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round q*.30 cordic value to q1.14 with clamp
  function automatic logic signed [15:0] round_q14(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) return ROT_MAX;
    if (r < -34'sd16384) return ROT_MIN;
    return r[15:0];
  endfunction

  // product of two q1.14 values, rounded and clamped
  function automatic logic signed [15:0] rot_mul(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [31:0] p;
    p = ((32'(a) * 32'(b)) + 32'sd8192) >>> 14;
    if (p > 32'sd16384) return ROT_MAX;
    if (p < -32'sd16384) return ROT_MIN;
    return p[15:0];
  endfunction

  // q1.14 factor times q15.8 length, saturated to 24 bits
  function automatic logic signed [23:0] pos_mul(input logic signed [16:0] f,
                                                 input logic signed [23:0] d);
    logic signed [41:0] p;
    p = ((42'(f) * 42'(d)) + 42'sd8192) >>> 14;
    if (p > 42'sd8388607) return 24'sh7FFFFF;
    if (p < -42'sd8388608) return 24'sh800000;
    return p[23:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/dh_link_transform.sv =====
`timescale 1ns / 1ps
`default_nettype none
// modified denavit-hartenberg link transform, fixed point
// in_ channel: one word per link (twist, length, offset, joint angle)
// out_ channel: one word per link with the eleven non-constant entries
//   of the homogeneous link transform, rotation q1.14, position q15.8
// both angles run through their own unrolled cordic, one stage per
//   register, both in lockstep
// pipeline: the registers from acceptance to out_valid are the fold,
//   cordic stages, rounding, products and output register
// throughput: one word per cycle; the pipe advances whenever the output
//   register is empty or being taken
// receiver stall: full stages hold while empty ones still fill, nothing
//   is lost or repeated; in_ready falls only when the output word is
//   stalled and every stage behind it is full
// reset: synchronous rst_n clears all valid bits; payload is not reset
module dh_link_transform
  import dhlt_pkg::*;
#(
  parameter int CORDIC_STAGES = 14
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dhlt_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output dhlt_out_t      out_data
);

  localparam int NS = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int NP = NS + 4; // total valid-bit stages

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               neg;
  } cord_t;

  // valid chain, stage k valid is vld_r[k]
  logic [NP-1:0] vld_r;
  logic [NP-1:0] adv;

  // stage advance: a stage moves if the one ahead moves or is empty
  always_comb begin
    adv[NP-1] = !vld_r[NP-1] || out_ready;
    for (int k = NP-2; k >= 0; k--) adv[k] = adv[k+1] || !vld_r[k];
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NP; k++) if (adv[k]) vld_r[k] <= vld_r[k-1];
    end
  end

  // stage 0: quadrant fold into [-pi/2, pi/2]
  function automatic cord_t fold(input logic signed [15:0] a);
    cord_t c;
    logic signed [33:0] z;
    z = 34'(a) <<< 17;
    c.neg = 1'b0;
    if (z > HALF_PI_Q30) begin
      z = z - PI_Q30; c.neg = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z = z + PI_Q30; c.neg = 1'b1;
    end
    c.x = GAIN_Q30; c.y = '0; c.z = z;
    return c;
  endfunction

  // cordic stages
  function automatic cord_t rot(input cord_t c, input int i);
    cord_t o;
    o.neg = c.neg;
    if (!c.z[33]) begin
      o.x = c.x - (c.y >>> i); o.y = c.y + (c.x >>> i); o.z = c.z - atan_q30(i);
    end else begin
      o.x = c.x + (c.y >>> i); o.y = c.y - (c.x >>> i); o.z = c.z + atan_q30(i);
    end
    return o;
  endfunction

  cord_t th_r [NS+1];
  cord_t al_r [NS+1];
  logic signed [23:0] len_r [NS+2];
  logic signed [23:0] off_r [NS+2];

  // fold, cordic stages and the length/offset delay line
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      th_r[0]  <= fold(in_data.joint_angle);
      al_r[0]  <= fold(in_data.twist_angle);
      len_r[0] <= in_data.link_length;
      off_r[0] <= in_data.link_offset;
    end
    for (int k = 0; k < NS; k++) begin
      if (adv[k+1]) begin
        th_r[k+1]  <= rot(th_r[k], k);
        al_r[k+1]  <= rot(al_r[k], k);
        len_r[k+1] <= len_r[k];
        off_r[k+1] <= off_r[k];
      end
    end
    if (adv[NS+1]) begin
      len_r[NS+1] <= len_r[NS];
      off_r[NS+1] <= off_r[NS];
    end
  end

  // rounding to q1.14
  logic signed [15:0] ct_r, st_r, ca_r, sa_r;
  always_ff @(posedge clk) begin
    if (adv[NS+1]) begin
      ct_r <= round_q14(th_r[NS].neg ? -th_r[NS].x : th_r[NS].x);
      st_r <= round_q14(th_r[NS].neg ? -th_r[NS].y : th_r[NS].y);
      ca_r <= round_q14(al_r[NS].neg ? -al_r[NS].x : al_r[NS].x);
      sa_r <= round_q14(al_r[NS].neg ? -al_r[NS].y : al_r[NS].y);
    end
  end

  // products
  dhlt_out_t prod_r;
  always_ff @(posedge clk) begin
    if (adv[NS+2]) begin
      prod_r.r00 <= ct_r;
      prod_r.r01 <= -st_r;
      prod_r.px  <= len_r[NS+1];
      prod_r.r10 <= rot_mul(st_r, ca_r);
      prod_r.r11 <= rot_mul(ct_r, ca_r);
      prod_r.r12 <= -sa_r;
      prod_r.py  <= pos_mul(-17'(sa_r), off_r[NS+1]);
      prod_r.r20 <= rot_mul(st_r, sa_r);
      prod_r.r21 <= rot_mul(ct_r, sa_r);
      prod_r.r22 <= ca_r;
      prod_r.pz  <= pos_mul(17'(ca_r), off_r[NS+1]);
    end
  end

  // output register
  dhlt_out_t out_r;
  always_ff @(posedge clk) begin
    if (adv[NS+3]) out_r <= prod_r;
  end
  assign out_data  = out_r;
  assign out_valid = vld_r[NP-1];

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("pipe blocked with receiver ready");
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r) && !out_ready)
    else $error("input refused with room in the pipe");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_dh_link_transform.sv =====
`timescale 1ns / 1ps
module tb_dh_link_transform;
  import dhlt_pkg::*;

  localparam int STAGES = 14;
  localparam int LATENCY = STAGES + 4;
  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM = 750;
  localparam longint CYCLE_LIMIT = 400000;

  // fixed-point helpers for the expected link transform
  localparam longint PI_30 = 64'sd3373259426;
  localparam longint HALF_PI_30 = 64'sd1686629713;
  localparam longint CORDIC_GAIN_30 = 64'sd652032874;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint limit_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint arctan_q30(int i);
    longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                      262143, 131071, 65535, 32767, 16383, 8191,
                      4095, 2047, 1023, 511, 255, 127};
    return t[i];
  endfunction

  // rotation-mode cordic after a quadrant fold, rounded to q1.14
  function automatic void angle_to_cos_sin(input logic signed [15:0] ang, output longint c,
                                           output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 131072;
    x = CORDIC_GAIN_30;
    y = 0;
    flip = 0;
    if (z > HALF_PI_30) begin
      z -= PI_30; flip = 1;
    end else if (z < -HALF_PI_30) begin
      z += PI_30; flip = 1;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= arctan_q30(i);
      end else begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += arctan_q30(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = limit_to(shr_floor(x + 32768, 16), -16384, 16384);
    s = limit_to(shr_floor(y + 32768, 16), -16384, 16384);
  endfunction

  function automatic longint rot_product(longint a, longint b);
    return limit_to(shr_floor(a * b + 8192, 14), -16384, 16384);
  endfunction

  function automatic longint pos_product(longint f, longint d);
    return limit_to(shr_floor(f * d + 8192, 14), -8388608, 8388607);
  endfunction

  function automatic dhlt_out_t link_transform(dhlt_in_t w);
    dhlt_out_t r;
    longint ct, st, ca, sa;
    angle_to_cos_sin(w.joint_angle, ct, st);
    angle_to_cos_sin(w.twist_angle, ca, sa);
    r.r00 = 16'(ct);
    r.r01 = 16'(-st);
    r.px  = w.link_length;
    r.r10 = 16'(rot_product(st, ca));
    r.r11 = 16'(rot_product(ct, ca));
    r.r12 = 16'(-sa);
    r.py  = 24'(pos_product(-sa, longint'(w.link_offset)));
    r.r20 = 16'(rot_product(st, sa));
    r.r21 = 16'(rot_product(ct, sa));
    r.r22 = 16'(ca);
    r.pz  = 24'(pos_product(ca, longint'(w.link_offset)));
    return r;
  endfunction

  // queue of expected transforms, compared word by word
  class transform_board;
    dhlt_out_t pending[$];
    int mismatches = 0;
    int checked = 0;

    function void note_link(dhlt_in_t w);
      pending.push_back(link_transform(w));
    endfunction

    function void report(string f, longint e, longint a);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0s: expected %0d actual %0d (word %0d)", f, e, a, checked);
    endfunction

    function void check_word(dhlt_out_t got);
      dhlt_out_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.r00 !== e.r00) report("r00", e.r00, got.r00);
      if (got.r01 !== e.r01) report("r01", e.r01, got.r01);
      if (got.px  !== e.px)  report("px",  e.px,  got.px);
      if (got.r10 !== e.r10) report("r10", e.r10, got.r10);
      if (got.r11 !== e.r11) report("r11", e.r11, got.r11);
      if (got.r12 !== e.r12) report("r12", e.r12, got.r12);
      if (got.py  !== e.py)  report("py",  e.py,  got.py);
      if (got.r20 !== e.r20) report("r20", e.r20, got.r20);
      if (got.r21 !== e.r21) report("r21", e.r21, got.r21);
      if (got.r22 !== e.r22) report("r22", e.r22, got.r22);
      if (got.pz  !== e.pz)  report("pz",  e.pz,  got.pz);
      checked++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  dhlt_in_t in_data;
  logic out_valid;
  logic out_ready;
  dhlt_out_t out_data;

  transform_board board;
  int sender_idle_pct;
  int receiver_stall_pct;
  bit hold_receiver;
  longint cycles;

  dh_link_transform #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog, counted in clock cycles
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // accepted words are scored at the edge that takes them
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_link(in_data);
    if (rst_n && out_valid && out_ready) board.check_word(out_data);
  end

  // receiver: random stall, or a long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_receiver) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // offer one word, keeping it steady until taken; idle gaps before it
  task automatic send_link(input dhlt_in_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'($urandom);
      // near the fold points at plus or minus pi/2 (12868 in q3.13)
      1: return 16'sd12868 + 16'($signed($urandom_range(40)) - 20);
      2: return -16'sd12868 + 16'($signed($urandom_range(40)) - 20);
      // near plus or minus pi
      3: return ($urandom_range(1) ? 16'sd25736 : -16'sd25736) +
                16'($signed($urandom_range(40)) - 20);
      default: return 16'($signed($urandom_range(25736 * 2)) - 25736);
    endcase
  endfunction

  function automatic logic signed [23:0] pick_length();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return $urandom_range(1) ? 24'sh7FFFFF - 24'($urandom_range(255))
                                  : 24'sh800000 + 24'($urandom_range(255));
      default: return 24'($signed($urandom_range(20000)) - 10000);
    endcase
  endfunction

  function automatic dhlt_in_t random_link();
    dhlt_in_t w;
    w.twist_angle = pick_angle();
    w.link_length = pick_length();
    w.link_offset = pick_length();
    w.joint_angle = pick_angle();
    return w;
  endfunction

  function automatic dhlt_in_t make_link(logic signed [15:0] al, logic signed [23:0] a,
                                         logic signed [23:0] d, logic signed [15:0] th);
    dhlt_in_t w;
    w.twist_angle = al; w.link_length = a; w.link_offset = d; w.joint_angle = th;
    return w;
  endfunction

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    dhlt_in_t directed[N_DIRECTED];
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_receiver = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, exact quadrant boundaries, both folds, saturating offsets
    directed = '{
      make_link(16'sh0000, 24'sh000000, 24'sh000000, 16'sh0000),
      make_link(16'sh7FFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF),
      make_link(16'sh8000, 24'sh800000, 24'sh800000, 16'sh8000),
      make_link(16'sh7FFF, 24'sh800000, 24'sh7FFFFF, 16'sh8000),
      make_link(16'sd12868, 24'sd256, 24'sh7FFFFF, 16'sd12868),
      make_link(16'sd12869, 24'sd256, 24'sh800000, 16'sd12869),
      make_link(-16'sd12868, 24'sd256, 24'sh7FFFFF, -16'sd12868),
      make_link(-16'sd12869, -24'sd256, 24'sh800000, -16'sd12869),
      make_link(16'sd25736, 24'sd1, 24'sh7FFFFF, 16'sd25736),
      make_link(-16'sd25736, -24'sd1, 24'sh800000, -16'sd25736),
      make_link(16'sd6434, 24'sd1000, 24'sd1000, 16'sd6434),
      make_link(-16'sd6434, 24'sd1000, -24'sd1000, 16'sd19302),
      make_link(16'sd0, 24'sh7FFFFF, 24'sh7FFFFF, 16'sd0),
      make_link(16'sd0, 24'sh800000, 24'sh800000, 16'sd0),
      make_link(16'sd25736, 24'sd5, 24'sh7FFFFF, -16'sd1),
      make_link(16'sd25736, 24'sd5, 24'sh800000, 16'sd1),
      make_link(16'sh5555, 24'sh555555, 24'sh555555, 16'sh5555),
      make_link(16'shAAAA, 24'shAAAAAA, 24'shAAAAAA, 16'shAAAA),
      make_link(16'sd1, 24'sd1, 24'sd1, 16'sd1),
      make_link(-16'sd1, -24'sd1, -24'sd1, -16'sd1),
      make_link(16'sd8192, 24'sd256, 24'sd256, -16'sd8192),
      make_link(-16'sd24000, 24'sd777, -24'sd777, 16'sd24000)
    };
    foreach (directed[k]) send_link(directed[k]);

    // random phases with different idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
        default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
      endcase
      for (int k = 0; k < N_RANDOM / 4; k++) send_link(random_link());
    end

    // long receiver hold-off: the pipe fills and in_ready must drop
    sender_idle_pct = 0;
    receiver_stall_pct = 10;
    fork
      begin
        hold_receiver = 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_receiver = 1'b0;
      end
      for (int k = 0; k < 2 * LATENCY + 10; k++) send_link(random_link());
    join
    in_valid <= 1'b0;

    drain();
    $display("covered %0d link words: extreme and fold-boundary angles, saturating offsets,",
             board.checked);
    $display("random idling on both sides and a long output hold-off");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
